>>> src/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds request codes, register indexes, sequencer states and fixed constants.
// No dependencies.
package ffea_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CFG_IW   = 2;

  localparam logic [DATA_W-1:0] DATA_BASE  = 64'd4096;
  localparam int unsigned       SLOT_SHIFT = 9;
  localparam logic [DATA_W-1:0] ALIGN_MASK = 64'd63;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_SLOT_COUNT  = 2'd0,
    REG_REGION_SIZE = 2'd1,
    REG_SPARE2      = 2'd2,
    REG_SPARE3      = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_END,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_Q_RD,
    S_Q_GAP,
    S_Q_FIT,
    S_Q_END,
    S_Q_RND,
    S_FIN_A,
    S_FIN_B,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic              carry;
  } alu_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] fin;
  } extent_t;

endpackage

>>> src/ffea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ffea_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/ffea_alu.sv
// Shared 64-bit add/subtract unit with carry out (carry set on subtract means a >= b).
// Depends on ffea_pkg.
module ffea_alu (
  input  ffea_pkg::alu_req_t req,
  output ffea_pkg::alu_res_t res
);

  logic [ffea_pkg::DATA_W-1:0] b_op;
  logic [ffea_pkg::DATA_W:0]   total;

  assign b_op  = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_op} + {{ffea_pkg::DATA_W{1'b0}}, req.sub};

  assign res.sum   = total[ffea_pkg::DATA_W-1:0];
  assign res.carry = total[ffea_pkg::DATA_W];

endmodule

>>> src/first_fit_extent_allocator.sv
// First-fit extent allocator: sorted extent store in one RAM, walked by a
// sequencer around a single shared 64-bit add/subtract unit. One request at a time.
// Clear, ignored or dropped loads finish straight from idle. A load shifts every stored
// extent with a larger start up one slot and stops at a smaller or equal start. A query
// walks the extents in start order until a gap fits; ready returns with the result.
// Synchronous active-low reset empties the store and clears state, count and config.
module first_fit_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ffea_pkg::FUNC_W-1:0]       in_func,
  input  logic [ffea_pkg::DATA_W-1:0]       in_extent_start,
  input  logic [ffea_pkg::DATA_W-1:0]       in_extent_length,
  input  logic                              in_extent_usable,
  input  logic [ffea_pkg::DATA_W-1:0]       in_request_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [ffea_pkg::DATA_W-1:0]       out_alloc_offset,
  input  logic                              cfg_we,
  input  logic [ffea_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [ffea_pkg::DATA_W-1:0]       cfg_wdata
);

  localparam int unsigned AW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned EW  = 2 * ffea_pkg::DATA_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  ffea_pkg::state_t state_r, state_nxt;

  logic [ffea_pkg::SLOT_W-1:0] slot_count_r;
  logic [ffea_pkg::DATA_W-1:0] region_size_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [ffea_pkg::DATA_W-1:0] start_r, start_nxt;
  logic [ffea_pkg::DATA_W-1:0] end_r, end_nxt;
  logic [ffea_pkg::DATA_W-1:0] want_r, want_nxt;
  logic [ffea_pkg::DATA_W-1:0] cursor_r, cursor_nxt;
  logic [ffea_pkg::DATA_W-1:0] diff_r, diff_nxt;
  logic                        ge_r, ge_nxt;
  logic                        res_found_r, res_found_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [ffea_pkg::DATA_W-1:0] out_offset_r, out_offset_nxt;

  logic                        in_acc;
  ffea_pkg::func_t             func;
  ffea_pkg::alu_req_t          alu_req;
  ffea_pkg::alu_res_t          alu_res;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  ffea_pkg::extent_t           ram_wdata, ram_rdata;
  logic [EW-1:0]               ram_rbits;
  logic [ffea_pkg::DATA_W-1:0] cursor_init;

  assign in_ready  = (state_r == ffea_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign func      = ffea_pkg::func_t'(in_func);
  assign ram_rdata = ram_rbits;
  assign cursor_init = ffea_pkg::DATA_BASE
                     + (ffea_pkg::DATA_W'(slot_count_r) << ffea_pkg::SLOT_SHIFT);

  ffea_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ffea_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EXTENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffea_pkg::S_IDLE: begin
        if (in_acc) begin
          case (func)
            ffea_pkg::FUNC_LOAD: begin
              if (in_extent_usable && (count_r < CNT_MAX)) begin
                state_nxt = ffea_pkg::S_INS_END;
              end
            end
            ffea_pkg::FUNC_QUERY: state_nxt = ffea_pkg::S_Q_RD;
            default:              state_nxt = ffea_pkg::S_IDLE;
          endcase
        end
      end
      ffea_pkg::S_INS_END: state_nxt = ffea_pkg::S_INS_RD;
      ffea_pkg::S_INS_RD: begin
        state_nxt = (idx_r == '0) ? ffea_pkg::S_INS_PUT : ffea_pkg::S_INS_CMP;
      end
      ffea_pkg::S_INS_CMP: begin
        state_nxt = alu_res.carry ? ffea_pkg::S_INS_PUT : ffea_pkg::S_INS_RD;
      end
      ffea_pkg::S_INS_PUT: state_nxt = ffea_pkg::S_IDLE;
      ffea_pkg::S_Q_RD: begin
        state_nxt = (idx_r == count_r) ? ffea_pkg::S_FIN_A : ffea_pkg::S_Q_GAP;
      end
      ffea_pkg::S_Q_GAP: state_nxt = ffea_pkg::S_Q_FIT;
      ffea_pkg::S_Q_FIT: begin
        state_nxt = (ge_r && alu_res.carry) ? ffea_pkg::S_FIN_A : ffea_pkg::S_Q_END;
      end
      ffea_pkg::S_Q_END: begin
        state_nxt = alu_res.carry ? ffea_pkg::S_Q_RD : ffea_pkg::S_Q_RND;
      end
      ffea_pkg::S_Q_RND: state_nxt = ffea_pkg::S_Q_RD;
      ffea_pkg::S_FIN_A: state_nxt = ffea_pkg::S_FIN_B;
      ffea_pkg::S_FIN_B: state_nxt = ffea_pkg::S_OUT;
      ffea_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ffea_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffea_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    want_nxt       = want_r;
    cursor_nxt     = cursor_r;
    diff_nxt       = diff_r;
    ge_nxt         = ge_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_offset_nxt = out_offset_r;
    alu_req        = '{a: start_r, b: end_r, sub: 1'b0};
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = '{start: start_r, fin: end_r};
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      ffea_pkg::S_IDLE: begin
        if (in_acc) begin
          start_nxt  = in_extent_start;
          end_nxt    = in_extent_length;
          want_nxt   = in_request_size;
          cursor_nxt = cursor_init;
          idx_nxt    = (func == ffea_pkg::FUNC_LOAD) ? count_r : '0;
          if (func == ffea_pkg::FUNC_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      ffea_pkg::S_INS_END: begin
        alu_req = '{a: start_r, b: end_r, sub: 1'b0};
        end_nxt = alu_res.sum;
      end
      ffea_pkg::S_INS_RD: begin
        ram_re    = (idx_r != '0);
        ram_raddr = AW'(idx_r - CNT_ONE);
      end
      ffea_pkg::S_INS_CMP: begin
        alu_req = '{a: start_r, b: ram_rdata.start, sub: 1'b1};
        if (!alu_res.carry) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CNT_ONE;
        end
      end
      ffea_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        count_nxt = count_r + CNT_ONE;
      end
      ffea_pkg::S_Q_RD: begin
        ram_re = (idx_r != count_r);
      end
      ffea_pkg::S_Q_GAP: begin
        alu_req  = '{a: ram_rdata.start, b: cursor_r, sub: 1'b1};
        diff_nxt = alu_res.sum;
        ge_nxt   = alu_res.carry;
      end
      ffea_pkg::S_Q_FIT: begin
        alu_req = '{a: diff_r, b: want_r, sub: 1'b1};
      end
      ffea_pkg::S_Q_END: begin
        alu_req = '{a: cursor_r, b: ram_rdata.fin, sub: 1'b1};
        if (alu_res.carry) begin
          idx_nxt = idx_r + CNT_ONE;
        end
      end
      ffea_pkg::S_Q_RND: begin
        alu_req    = '{a: ram_rdata.fin, b: ffea_pkg::ALIGN_MASK, sub: 1'b0};
        cursor_nxt = alu_res.carry ? '1 : (alu_res.sum & ~ffea_pkg::ALIGN_MASK);
        idx_nxt    = idx_r + CNT_ONE;
      end
      ffea_pkg::S_FIN_A: begin
        alu_req  = '{a: region_size_r, b: cursor_r, sub: 1'b1};
        diff_nxt = alu_res.sum;
        ge_nxt   = alu_res.carry;
      end
      ffea_pkg::S_FIN_B: begin
        alu_req       = '{a: diff_r, b: want_r, sub: 1'b1};
        res_found_nxt = ge_r && alu_res.carry;
      end
      ffea_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_offset_nxt = res_found_r ? cursor_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ffea_pkg::S_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      slot_count_r  <= '0;
      region_size_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (ffea_pkg::cfg_reg_t'(cfg_index))
          ffea_pkg::REG_SLOT_COUNT:  slot_count_r  <= cfg_wdata[ffea_pkg::SLOT_W-1:0];
          ffea_pkg::REG_REGION_SIZE: region_size_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    want_r       <= want_nxt;
    cursor_r     <= cursor_nxt;
    diff_r       <= diff_nxt;
    ge_r         <= ge_nxt;
    res_found_r  <= res_found_nxt;
    out_found_r  <= out_found_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_alloc_offset = out_offset_r;

endmodule

>>> verif/tb_first_fit_extent_allocator.sv
// Testbench for first_fit_extent_allocator: directed and random clear, load and query requests
// with a first-fit predictor in a small scoreboard class and random stalls on both channels.
// Depends on ffea_pkg and the first_fit_extent_allocator RTL.
module tb_first_fit_extent_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH    = 64;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned N_PHASES       = 9;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DW             = ffea_pkg::DATA_W;
  localparam int unsigned SW             = ffea_pkg::SLOT_W;

  typedef struct packed {
    logic          found;
    logic [DW-1:0] offset;
  } alloc_result_t;

  class alloc_checker;
    logic [DW-1:0] ext_start[STORE_DEPTH];
    logic [DW-1:0] ext_end[STORE_DEPTH];
    int unsigned   n_ext = 0;
    logic [SW-1:0] slot_count = '0;
    logic [DW-1:0] region_size = '0;
    alloc_result_t expected_allocs[$];
    int unsigned   fails = 0;

    function void set_reg(ffea_pkg::cfg_reg_t idx, logic [DW-1:0] data);
      case (idx)
        ffea_pkg::REG_SLOT_COUNT:  slot_count = data[SW-1:0];
        ffea_pkg::REG_REGION_SIZE: region_size = data;
        default: ;
      endcase
    endfunction

    function void note_request(ffea_pkg::func_t f, logic [DW-1:0] s, logic [DW-1:0] l,
                               logic u, logic [DW-1:0] want);
      int unsigned   pos;
      int unsigned   i;
      logic [DW-1:0] cursor;
      alloc_result_t res;
      case (f)
        ffea_pkg::FUNC_CLEAR: n_ext = 0;
        ffea_pkg::FUNC_LOAD: begin
          if (u && n_ext < STORE_DEPTH) begin
            pos = n_ext;
            while (pos > 0 && ext_start[pos-1] > s) begin
              ext_start[pos] = ext_start[pos-1];
              ext_end[pos]   = ext_end[pos-1];
              pos--;
            end
            ext_start[pos] = s;
            ext_end[pos]   = s + l;
            n_ext++;
          end
        end
        ffea_pkg::FUNC_QUERY: begin
          cursor = ffea_pkg::DATA_BASE
                 + ({{(DW-SW){1'b0}}, slot_count} << ffea_pkg::SLOT_SHIFT);
          for (i = 0; i < n_ext; i++) begin
            if (ext_start[i] >= cursor && want <= ext_start[i] - cursor) break;
            if (ext_end[i] > cursor)
              cursor = (ext_end[i] > ~ffea_pkg::ALIGN_MASK) ? '1
                     : (ext_end[i] + ffea_pkg::ALIGN_MASK) & ~ffea_pkg::ALIGN_MASK;
          end
          res.found  = !(cursor > region_size || want > region_size - cursor);
          res.offset = res.found ? cursor : '0;
          expected_allocs.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_alloc(logic found, logic [DW-1:0] offset);
      alloc_result_t exp_res;
      if (expected_allocs.size() == 0) begin
        $error("unexpected result: found %0d offset 0x%016h", found, offset);
        fails++;
      end else begin
        exp_res = expected_allocs.pop_front();
        if (found !== exp_res.found) begin
          $error("found: expected %0d, actual %0d", exp_res.found, found);
          fails++;
        end
        if (offset !== exp_res.offset) begin
          $error("alloc_offset: expected 0x%016h, actual 0x%016h", exp_res.offset, offset);
          fails++;
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [ffea_pkg::FUNC_W-1:0] in_func;
  logic [DW-1:0]               in_extent_start;
  logic [DW-1:0]               in_extent_length;
  logic                        in_extent_usable;
  logic [DW-1:0]               in_request_size;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_found;
  logic [DW-1:0]               out_alloc_offset;
  logic                        cfg_we;
  logic [ffea_pkg::CFG_IW-1:0] cfg_index;
  logic [DW-1:0]               cfg_wdata;

  alloc_checker alloc_chk;
  bit           no_idle = 1'b0;
  bit           hold_results = 1'b0;
  int unsigned  sent_items = 0;

  first_fit_extent_allocator #(
    .MAX_EXTENTS(STORE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_extent_start  (in_extent_start),
    .in_extent_length (in_extent_length),
    .in_extent_usable (in_extent_usable),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_alloc_offset (out_alloc_offset),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_request(ffea_pkg::func_t f, logic [DW-1:0] s, logic [DW-1:0] l,
                              logic u, logic [DW-1:0] want);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func          = f;
    in_extent_start  = s;
    in_extent_length = l;
    in_extent_usable = u;
    in_request_size  = want;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    alloc_chk.note_request(f, s, l, u, want);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(ffea_pkg::cfg_reg_t idx, logic [DW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    alloc_chk.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic settle();
    in_valid = 1'b0;
    while (alloc_chk.expected_allocs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned quota);
    int unsigned   goal;
    int unsigned   n_loads;
    logic [DW-1:0] base;
    logic [DW-1:0] s;
    logic [DW-1:0] l;
    logic [DW-1:0] want;
    goal = sent_items + quota;
    base = ffea_pkg::DATA_BASE
         + ({{(DW-SW){1'b0}}, alloc_chk.slot_count} << ffea_pkg::SLOT_SHIFT);
    while (sent_items < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 4) != 0)
          send_request(ffea_pkg::FUNC_CLEAR, rand64(), rand64(), 1'($urandom), rand64());
        n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
        repeat (n_loads) begin
          case ($urandom_range(0, 9))
            0: begin
              s = rand64();
              l = rand64();
            end
            1: begin
              s = ~64'd0 - $urandom_range(0, 4096);
              l = 64'($urandom_range(0, 8192));
            end
            default: begin
              s = base + $urandom_range(0, 65535);
              l = 64'($urandom_range(0, 4096));
            end
          endcase
          send_request(ffea_pkg::FUNC_LOAD, s, l, $urandom_range(0, 9) != 0, rand64());
        end
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 9))
            0: want = rand64();
            1: want = '1;
            2: want = '0;
            default: want = 64'($urandom_range(0, 8192));
          endcase
          send_request(ffea_pkg::FUNC_QUERY, rand64(), rand64(), 1'($urandom), want);
        end
      end else begin
        send_request(ffea_pkg::func_t'($urandom_range(0, 3)), rand64(), rand64(),
                     1'($urandom), rand64());
      end
    end
  endtask

  initial begin
    int unsigned   p;
    logic [SW-1:0] slot;
    logic [DW-1:0] region;
    alloc_chk        = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = ffea_pkg::FUNC_CLEAR;
    in_extent_start  = '0;
    in_extent_length = '0;
    in_extent_usable = 1'b0;
    in_request_size  = '0;
    cfg_we           = 1'b0;
    cfg_index        = ffea_pkg::REG_SLOT_COUNT;
    cfg_wdata        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(ffea_pkg::REG_SLOT_COUNT, '0);
    write_reg(ffea_pkg::REG_REGION_SIZE, '1);

    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, '1);
    send_request(ffea_pkg::FUNC_LOAD, 64'd4096, 64'd100, 1'b0, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd1);
    send_request(ffea_pkg::FUNC_LOAD, 64'd4096, 64'd100, 1'b1, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd1);
    send_request(ffea_pkg::FUNC_LOAD, 64'd8192, 64'd64, 1'b1, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd3968);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd3969);
    send_request(ffea_pkg::FUNC_LOAD, 64'd5000, 64'd10, 1'b1, '0);
    send_request(ffea_pkg::FUNC_LOAD, 64'd5000, 64'd3000, 1'b1, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd1);
    send_request(ffea_pkg::FUNC_LOAD, ~64'd0 - 64'd99, 64'd200, 1'b1, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd64);
    send_request(ffea_pkg::FUNC_NONE, '1, '1, 1'b1, '1);
    send_request(ffea_pkg::FUNC_LOAD, ~64'd0 - 64'd1000, 64'd999, 1'b1, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, '0);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, 64'd1);
    send_request(ffea_pkg::FUNC_LOAD, '1, '1, 1'b1, '1);
    send_request(ffea_pkg::FUNC_QUERY, rand64(), rand64(), 1'b1, rand64());
    send_request(ffea_pkg::FUNC_CLEAR, '1, '1, 1'b1, '1);
    send_request(ffea_pkg::FUNC_QUERY, '0, '0, 1'b0, '0);
    run_phase(PHASE_ITEMS);

    for (p = 1; p < N_PHASES; p++) begin
      settle();
      case (p)
        1: begin
          slot   = 7'd64;
          region = '1;
        end
        2: begin
          slot   = '0;
          region = '0;
          write_reg(ffea_pkg::REG_SPARE2, rand64());
          write_reg(ffea_pkg::REG_SPARE3, rand64());
        end
        3: begin
          slot   = 7'd64;
          region = ffea_pkg::DATA_BASE + (64'd64 << ffea_pkg::SLOT_SHIFT)
                 + $urandom_range(0, 100000);
        end
        default: begin
          slot = 7'($urandom_range(0, 64));
          case ($urandom_range(0, 3))
            0: region = rand64();
            1: region = '1;
            default: region = ffea_pkg::DATA_BASE
                              + ({{(DW-SW){1'b0}}, slot} << ffea_pkg::SLOT_SHIFT)
                              + $urandom_range(0, 100000);
          endcase
        end
      endcase
      if (p > 3)
        write_reg(ffea_pkg::REG_SLOT_COUNT,
                  (rand64() & ~64'h7F) | {{(DW-SW){1'b0}}, slot});
      else
        write_reg(ffea_pkg::REG_SLOT_COUNT, {{(DW-SW){1'b0}}, slot});
      write_reg(ffea_pkg::REG_REGION_SIZE, region);
      no_idle = (p == 2 || p == 5);
      if (p == 1 || p == 6) hold_results = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    settle();
    if (alloc_chk.fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end
      stall = draw_gap();
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      alloc_chk.check_alloc(out_found, out_alloc_offset);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
src/ffea_pkg.sv
src/ffea_ram.sv
src/ffea_alu.sv
src/first_fit_extent_allocator.sv
verif/tb_first_fit_extent_allocator.sv
